/* sv/priority_bitmap_run_queue_unit_macros.svh */
// ----------------------------------------------------------------------------
// priority bitmap run queue assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BITMAP_RUN_QUEUE_UNIT_MACROS_SVH
`define PRIORITY_BITMAP_RUN_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property holds at every edge
`define PBRQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pbrq assertion failed");
// same-cycle implication
`define PBRQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbrq implication failed");
// next-cycle implication
`define PBRQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbrq next-cycle implication failed");
`else
`define PBRQ_ASSERT(lbl, prop)
`define PBRQ_ASSERT_IMP(lbl, ante, cons)
`define PBRQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/pbrq_pkg.sv */
// ----------------------------------------------------------------------------
// pbrq_pkg
// shared constants, types and helper functions of the priority run queue
// ----------------------------------------------------------------------------
package pbrq_pkg;

    localparam int NUM_PRIOS = 64;
    localparam int NUM_TASKS = 64;
    localparam int ID_W      = 6;
    localparam int ROWS      = 8;
    localparam int COLS      = 8;
    localparam int QUEUE_AW  = $clog2(NUM_PRIOS);
    localparam int LINK_AW   = $clog2(NUM_TASKS);
    localparam int QUEUE_DW  = 2 * ID_W;

    typedef enum logic [0:0] {
        CMD_ADD    = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LINK
    } state_t;

    // bitmap update request
    typedef struct packed {
        logic            set;
        logic            clr;
        logic [ID_W-1:0] prio;
    } bitmap_op_t;

    // bitmap status, highest and any_ready reflect the pending update
    typedef struct packed {
        logic            level_ready;
        logic            any_ready;
        logic [ID_W-1:0] highest;
    } bitmap_stat_t;

    // position of the lowest set bit, zero for an empty byte
    function automatic logic [2:0] lowest_bit(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic prio_in_range(input logic [ID_W-1:0] p);
        return int'(p) < NUM_PRIOS;
    endfunction

    function automatic logic task_in_range(input logic [ID_W-1:0] t);
        return int'(t) < NUM_TASKS;
    endfunction

endpackage

/* sv/pbrq_ram.sv */
// ----------------------------------------------------------------------------
// pbrq_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module pbrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/pbrq_bitmap.sv */
// ----------------------------------------------------------------------------
// pbrq_bitmap
// two-level ready bitmap with lowest ready priority search
// ----------------------------------------------------------------------------
`include "priority_bitmap_run_queue_unit_macros.svh"

module pbrq_bitmap
    import pbrq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bitmap_op_t   op,
    output bitmap_stat_t stat
);

    logic [COLS-1:0] row_reg  [ROWS];
    logic [COLS-1:0] row_next [ROWS];
    logic [ROWS-1:0] group_reg;
    logic [ROWS-1:0] group_next;
    logic [2:0]      row;
    logic [2:0]      col;
    logic [2:0]      sel_row;

    assign row = op.prio[5:3];
    assign col = op.prio[2:0];

    always_comb
    begin
        row_next   = row_reg;
        group_next = group_reg;
        if (op.set)
        begin
            row_next[row][col] = 1'b1;
            group_next[row]    = 1'b1;
        end
        else if (op.clr)
        begin
            row_next[row][col] = 1'b0;
            if (row_next[row] == '0)
            begin
                group_next[row] = 1'b0;
            end
        end
    end

    // search runs on the updated bitmap
    always_comb
    begin
        sel_row          = lowest_bit(group_next);
        stat.level_ready = row_reg[row][col];
        stat.any_ready   = |group_next;
        stat.highest     = (group_next == '0) ? '0
                         : {sel_row, lowest_bit(row_next[sel_row])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                row_reg[r] <= '0;
            end
            group_reg <= '0;
        end
        else
        begin
            row_reg   <= row_next;
            group_reg <= group_next;
        end
    end

    `PBRQ_ASSERT(a_op_exclusive, !(op.set && op.clr))
    `PBRQ_ASSERT_IMP(a_group_covers_row, stat.level_ready, group_reg[row])
    `PBRQ_ASSERT_NEXT(a_set_takes_effect, op.set, row_reg[$past(row)][$past(col)])

endmodule

/* sv/priority_bitmap_run_queue_unit.sv */
// ----------------------------------------------------------------------------
// priority_bitmap_run_queue_unit
// ready-task scheduler: per-priority task fifos plus a two-level ready bitmap
// ----------------------------------------------------------------------------
// usage
//   command channel: cmd_valid / cmd_stall with command, task_id, prio
//   response channel: rsp_valid / rsp_stall with removed_task, removed_valid,
//   best_prio and any_ready, exactly one response item per command item
//   an add appends task_id to the fifo of prio, a remove pops its head
//   every response carries the lowest-numbered ready priority after the step
// sequencing
//   an item is accepted only while the sequencer is idle; the head/tail
//   memory is read in the accept cycle and written back once the response
//   register is free, with the response loaded at that point; an add, or a
//   remove that empties or misses its fifo, finishes in the exec state, a
//   remove that leaves entries behind goes on to the link state, the extra
//   step being the link memory read for the new head
// reset
//   rst_n clears the ready bitmap, the sequencer and the response valid;
//   the memories need no clearing, an entry is only read once written
// stall
//   a finished response sits in the output register; a new item can be
//   accepted meanwhile, but its write-back waits until the register frees
// ----------------------------------------------------------------------------
`include "priority_bitmap_run_queue_unit_macros.svh"

module priority_bitmap_run_queue_unit
    import pbrq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // command channel
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  logic            command,
    input  logic [ID_W-1:0] task_id,
    input  logic [ID_W-1:0] prio,
    // response channel
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output logic [ID_W-1:0] removed_task,
    output logic            removed_valid,
    output logic [ID_W-1:0] best_prio,
    output logic            any_ready
);

    // sequencer state and captured command item
    state_t          state_reg, state_next;
    cmd_t            cmd_reg;
    logic [ID_W-1:0] task_reg;
    logic [ID_W-1:0] prio_reg;

    // response register
    logic            rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0] removed_task_reg;
    logic            removed_valid_reg;
    logic [ID_W-1:0] highest_reg;
    logic            any_ready_reg;

    // memory ports
    logic                q_we;
    logic [QUEUE_AW-1:0] q_raddr;
    logic [QUEUE_DW-1:0] q_wdata;
    logic [QUEUE_DW-1:0] q_rdata;
    logic [ID_W-1:0]     q_head;
    logic [ID_W-1:0]     q_tail;
    logic                l_we;
    logic [ID_W-1:0]     l_rdata;

    // bitmap interface
    bitmap_op_t   bm_op;
    bitmap_stat_t bm_stat;

    // response load
    logic            rsp_free;
    logic            load;
    logic [ID_W-1:0] load_task;
    logic            load_valid;

    // head in the upper half, tail in the lower half of a queue entry
    assign q_head = q_rdata[QUEUE_DW-1:ID_W];
    assign q_tail = q_rdata[ID_W-1:0];

    // the read address follows the incoming item while idle, else the held one
    assign q_raddr = (state_reg == ST_IDLE) ? QUEUE_AW'(prio) : QUEUE_AW'(prio_reg);

    pbrq_ram #(
        .WIDTH (QUEUE_DW),
        .DEPTH (NUM_PRIOS)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (QUEUE_AW'(prio_reg)),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // links are written at the old tail and read at the current head
    pbrq_ram #(
        .WIDTH (ID_W),
        .DEPTH (NUM_TASKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (LINK_AW'(q_tail)),
        .wdata (task_reg),
        .raddr (LINK_AW'(q_head)),
        .rdata (l_rdata)
    );

    pbrq_bitmap u_bitmap (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (bm_op),
        .stat  (bm_stat)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next  = state_reg;
        q_we        = 1'b0;
        q_wdata     = {task_reg, task_reg};
        l_we        = 1'b0;
        bm_op.set   = 1'b0;
        bm_op.clr   = 1'b0;
        bm_op.prio  = prio_reg;
        load        = 1'b0;
        load_task   = '0;
        load_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // queue entry is on the read port now; hold while output is full
                if (rsp_free)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (prio_in_range(prio_reg) && task_in_range(task_reg))
                        begin
                            q_we      = 1'b1;
                            bm_op.set = 1'b1;
                            if (bm_op.set && bm_stat.level_ready)
                            begin
                                // append behind the current tail
                                l_we    = 1'b1;
                                q_wdata = {q_head, task_reg};
                            end
                        end
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (prio_in_range(prio_reg) && bm_stat.level_ready)
                    begin
                        if (q_head == q_tail)
                        begin
                            // last entry leaves, fifo becomes empty
                            bm_op.clr  = 1'b1;
                            load       = 1'b1;
                            load_task  = q_head;
                            load_valid = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_LINK;
                        end
                    end
                    else
                    begin
                        // remove from empty or out-of-range fifo
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LINK:
            begin
                // link of the popped head becomes the new head
                if (rsp_free)
                begin
                    q_we       = 1'b1;
                    q_wdata    = {l_rdata, q_tail};
                    load       = 1'b1;
                    load_task  = q_head;
                    load_valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item capture and response payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_valid)
        begin
            cmd_reg  <= cmd_t'(command);
            task_reg <= task_id;
            prio_reg <= prio;
        end
        if (load)
        begin
            removed_task_reg  <= load_task;
            removed_valid_reg <= load_valid;
            highest_reg       <= bm_stat.highest;
            any_ready_reg     <= bm_stat.any_ready;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign removed_task  = removed_task_reg;
    assign removed_valid = removed_valid_reg;
    assign best_prio     = highest_reg;
    assign any_ready     = any_ready_reg;

    `PBRQ_ASSERT_NEXT(a_accept_to_exec, cmd_valid && !cmd_stall, state_reg == ST_EXEC)
    `PBRQ_ASSERT_IMP(a_link_after_exec, state_reg == ST_LINK, $past(state_reg) != ST_IDLE)
    `PBRQ_ASSERT_IMP(a_idle_prio_zero, rsp_valid_reg && !any_ready_reg, highest_reg == '0)
    `PBRQ_ASSERT_IMP(a_no_pop_no_task, rsp_valid_reg && !removed_valid_reg, removed_task_reg == '0)

endmodule

/* test/priority_bitmap_run_queue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority bitmap run queue checker
// watches both channels, predicts every response from the accepted commands
// and compares the responses field by field in arrival order
// ----------------------------------------------------------------------------
module priority_bitmap_run_queue_checker
    import pbrq_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  logic            command,
    input  logic [ID_W-1:0] task_id,
    input  logic [ID_W-1:0] prio,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  logic [ID_W-1:0] removed_task,
    input  logic            removed_valid,
    input  logic [ID_W-1:0] best_prio,
    input  logic            any_ready,
    output int              mismatch_count,
    output int              outstanding,
    output int              responses_checked,
    output int              tasks_popped
);

    typedef struct packed {
        logic [ID_W-1:0] removed_task;
        logic            removed_valid;
        logic [ID_W-1:0] best_prio;
        logic            any_ready;
    } sched_response_t;

    // shadow scheduler state
    logic [7:0]      ready_rows [ROWS];
    logic [7:0]      ready_groups;
    logic [ID_W-1:0] fifo_head [NUM_PRIOS];
    logic [ID_W-1:0] fifo_tail [NUM_PRIOS];
    logic [ID_W-1:0] task_link [NUM_TASKS];

    sched_response_t predicted_responses[$];

    initial begin
        mismatch_count    = 0;
        outstanding       = 0;
        responses_checked = 0;
        tasks_popped      = 0;
    end

    function automatic logic [2:0] first_ready(input logic [7:0] bits);
        for (int i = 0; i < 8; i++) begin
            if (bits[i]) begin
                return 3'(i);
            end
        end
        return 3'd0;
    endfunction

    task automatic update_run_queue(input cmd_t cmd, input logic [ID_W-1:0] tid,
                                    input logic [ID_W-1:0] p);
        sched_response_t rsp;
        logic [2:0]      row;
        logic [2:0]      col;
        logic [2:0]      best_row;
        row = p[5:3];
        col = p[2:0];
        rsp = '0;
        if (cmd == CMD_ADD) begin
            if (int'(p) < NUM_PRIOS && int'(tid) < NUM_TASKS) begin
                if (ready_rows[row][col]) begin
                    task_link[fifo_tail[p]] = tid;
                end else begin
                    fifo_head[p] = tid;
                end
                fifo_tail[p]        = tid;
                ready_rows[row][col] = 1'b1;
                ready_groups[row]    = 1'b1;
            end
        end else if (int'(p) < NUM_PRIOS && ready_rows[row][col]) begin
            rsp.removed_task  = fifo_head[p];
            rsp.removed_valid = 1'b1;
            // the level goes idle only when its last task leaves
            if (fifo_head[p] == fifo_tail[p]) begin
                ready_rows[row][col] = 1'b0;
                if (ready_rows[row] == 8'd0) begin
                    ready_groups[row] = 1'b0;
                end
            end else begin
                fifo_head[p] = task_link[fifo_head[p]];
            end
        end
        if (ready_groups != 8'd0) begin
            best_row      = first_ready(ready_groups);
            rsp.best_prio = {best_row, first_ready(ready_rows[best_row])};
            rsp.any_ready = 1'b1;
        end
        predicted_responses.push_back(rsp);
    endtask

    task automatic compare_field(input string field, input logic [ID_W-1:0] want,
                                 input logic [ID_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch in response %0d, %s: expected %0d, got %0d",
                         responses_checked, field, want, got);
            end
        end
    endtask

    task automatic check_response();
        sched_response_t want;
        if (predicted_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("response with no command pending: task %0d valid %0b prio %0d any %0b",
                         removed_task, removed_valid, best_prio, any_ready);
            end
        end else begin
            want = predicted_responses.pop_front();
            compare_field("removed_task", want.removed_task, removed_task);
            compare_field("removed_valid", ID_W'(want.removed_valid), ID_W'(removed_valid));
            compare_field("best_prio", want.best_prio, best_prio);
            compare_field("any_ready", ID_W'(want.any_ready), ID_W'(any_ready));
            if (want.removed_valid) begin
                tasks_popped++;
            end
        end
        responses_checked++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ready_groups = 8'd0;
            for (int r = 0; r < ROWS; r++) begin
                ready_rows[r] = 8'd0;
            end
            for (int i = 0; i < NUM_PRIOS; i++) begin
                fifo_head[i] = '0;
                fifo_tail[i] = '0;
            end
            for (int i = 0; i < NUM_TASKS; i++) begin
                task_link[i] = '0;
            end
            predicted_responses.delete();
        end else begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
                check_response();
            end
            if (cmd_valid === 1'b1 && cmd_stall === 1'b0) begin
                update_run_queue(cmd_t'(command), task_id, prio);
            end
        end
        outstanding = predicted_responses.size();
    end

endmodule

/* test/priority_bitmap_run_queue_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority bitmap run queue unit test
// drives add and remove commands into the run queue, with directed corner
// cases first and then random task traffic, random idle bursts on both
// channels and one long response hold-off; a separate checker predicts and
// compares every response
// ----------------------------------------------------------------------------
module priority_bitmap_run_queue_unit_test;
    import pbrq_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run
    localparam int LONG_HOLD     = 300;     // cycles of the long response hold-off
    localparam int DRAIN_CYCLES  = 20;
    localparam int FIRST_RANDOM  = 300;
    localparam int PRESSURE_RUN  = 40;
    localparam int SECOND_RANDOM = 560;
    localparam int QUIET_TAIL    = 100;     // last items with no idling at all

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            cmd_valid     = 1'b0;
    logic            command       = 1'b0;
    logic [ID_W-1:0] task_id       = '0;
    logic [ID_W-1:0] prio          = '0;
    logic            rsp_stall     = 1'b0;
    logic            cmd_stall;
    logic            rsp_valid;
    logic [ID_W-1:0] removed_task;
    logic            removed_valid;
    logic [ID_W-1:0] best_prio;
    logic            any_ready;

    int mismatch_count;
    int outstanding;
    int responses_checked;
    int tasks_popped;

    // idling switches, flipped by the main sequence
    bit send_gaps    = 1'b1;
    bit recv_stalls  = 1'b1;
    // long hold-offs asked for vs. carried out by the receiver
    int hold_requests = 0;
    int holds_done    = 0;

    int adds_sent    = 0;
    int removes_sent = 0;
    int cycle_count  = 0;

    // what the stimulus side believes is queued, used only to shape traffic:
    // keeps task ids unique so every pop follows a link that was written
    logic [ID_W-1:0] waiting_tasks [NUM_PRIOS][$];
    bit [NUM_TASKS-1:0] task_busy = '0;
    logic [ID_W-1:0] hot_prios [4];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_bitmap_run_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .task_id       (task_id),
        .prio          (prio),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .removed_task  (removed_task),
        .removed_valid (removed_valid),
        .best_prio     (best_prio),
        .any_ready     (any_ready)
    );

    priority_bitmap_run_queue_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd_stall         (cmd_stall),
        .command           (command),
        .task_id           (task_id),
        .prio              (prio),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .removed_task      (removed_task),
        .removed_valid     (removed_valid),
        .best_prio         (best_prio),
        .any_ready         (any_ready),
        .mismatch_count    (mismatch_count),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .tasks_popped      (tasks_popped)
    );

    // present one command item and hold it until the block takes it;
    // an optional idle burst goes in front, valid stays high otherwise
    task automatic offer_item(input cmd_t cmd, input logic [ID_W-1:0] tid,
                              input logic [ID_W-1:0] p);
        int gap;
        gap = 0;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
        end
        if (gap > 0) begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        command   <= cmd;
        task_id   <= tid;
        prio      <= p;
        // accepted at the first rising edge with stall low
        @(posedge clk);
        while (cmd_stall) begin
            @(posedge clk);
        end
        if (cmd == CMD_ADD) begin
            adds_sent++;
        end else begin
            removes_sent++;
        end
    endtask

    task automatic shuffle_hot_prios();
        for (int i = 0; i < 4; i++) begin
            hot_prios[i] = ID_W'($urandom_range(0, NUM_PRIOS - 1));
        end
    endtask

    // one random command: mostly well-formed adds and pops on a few busy
    // levels, with removes on empty levels and random task ids as noise
    task automatic random_item();
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] tid;
        int              free_tasks;
        int              start;
        bit              do_add;
        bit              found;
        free_tasks = NUM_TASKS - $countones(task_busy);
        if (free_tasks == 0) begin
            do_add = 1'b0;
        end else if (free_tasks < 8) begin
            do_add = ($urandom_range(0, 9) < 3);
        end else begin
            do_add = ($urandom_range(0, 9) < 6);
        end

        if (do_add) begin
            if ($urandom_range(0, 9) < 7) begin
                p = hot_prios[$urandom_range(0, 3)];
            end else begin
                p = ID_W'($urandom_range(0, NUM_PRIOS - 1));
            end
            // first free task id from a random starting point
            start = $urandom_range(0, NUM_TASKS - 1);
            tid   = '0;
            for (int k = 0; k < NUM_TASKS; k++) begin
                if (!task_busy[(start + k) % NUM_TASKS] && !found) begin
                    tid   = ID_W'((start + k) % NUM_TASKS);
                    found = 1'b1;
                end
            end
            task_busy[tid] = 1'b1;
            waiting_tasks[p].push_back(tid);
            offer_item(CMD_ADD, tid, p);
        end else begin
            p = ID_W'($urandom_range(0, NUM_PRIOS - 1));
            if ($urandom_range(0, 9) < 8) begin
                // aim at a level that holds tasks
                start = $urandom_range(0, NUM_PRIOS - 1);
                for (int k = 0; k < NUM_PRIOS; k++) begin
                    if (waiting_tasks[(start + k) % NUM_PRIOS].size() > 0 && !found) begin
                        p     = ID_W'((start + k) % NUM_PRIOS);
                        found = 1'b1;
                    end
                end
            end
            if (waiting_tasks[p].size() > 0) begin
                tid            = waiting_tasks[p].pop_front();
                task_busy[tid] = 1'b0;
            end
            // task id is ignored by a remove, so it carries noise
            offer_item(CMD_REMOVE, ID_W'($urandom_range(0, NUM_TASKS - 1)), p);
        end
    endtask

    // response side: random stall bursts, plus the long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty remove, both ends of the priority range, append
        // behind a queued task, pop that leaves a task behind, pops that
        // empty a level, remove from an emptied level
        offer_item(CMD_REMOVE, 6'd63, 6'd0);
        offer_item(CMD_ADD,    6'd0,  6'd63);
        offer_item(CMD_ADD,    6'd63, 6'd63);
        offer_item(CMD_ADD,    6'd1,  6'd0);
        offer_item(CMD_REMOVE, 6'd63, 6'd0);
        offer_item(CMD_REMOVE, 6'd0,  6'd63);
        offer_item(CMD_REMOVE, 6'd63, 6'd63);
        offer_item(CMD_REMOVE, 6'd0,  6'd63);
        // duplicate add on the same level: the pop sees head equal to tail
        offer_item(CMD_ADD,    6'd5,  6'd10);
        offer_item(CMD_ADD,    6'd5,  6'd10);
        offer_item(CMD_REMOVE, 6'd0,  6'd10);
        // same task queued on two levels at once
        offer_item(CMD_ADD,    6'd7,  6'd20);
        offer_item(CMD_ADD,    6'd7,  6'd42);
        offer_item(CMD_REMOVE, 6'd0,  6'd20);
        offer_item(CMD_REMOVE, 6'd0,  6'd42);
        // group search across rows: last column of row 0, rows 1 and 7
        offer_item(CMD_ADD,    6'd40, 6'd56);
        offer_item(CMD_ADD,    6'd41, 6'd8);
        offer_item(CMD_ADD,    6'd42, 6'd7);
        offer_item(CMD_REMOVE, 6'd0,  6'd7);
        offer_item(CMD_REMOVE, 6'd0,  6'd8);
        offer_item(CMD_REMOVE, 6'd0,  6'd56);
        // every level is empty again here, matching the stimulus bookkeeping

        shuffle_hot_prios();
        for (int i = 0; i < FIRST_RANDOM; i++) begin
            if (i % 100 == 99) begin
                shuffle_hot_prios();
            end
            random_item();
        end

        // back-pressure: responses held off while commands keep coming
        send_gaps = 1'b0;
        hold_requests++;
        for (int i = 0; i < PRESSURE_RUN; i++) begin
            random_item();
        end

        for (int i = 0; i < SECOND_RANDOM; i++) begin
            if (i >= SECOND_RANDOM - QUIET_TAIL) begin
                send_gaps   = 1'b0;
                recv_stalls = 1'b0;
            end else if (i % 80 == 0) begin
                // mix busy stretches at random with idle-free ones
                send_gaps   = $urandom_range(0, 1);
                recv_stalls = $urandom_range(0, 1);
                shuffle_hot_prios();
            end
            random_item();
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (outstanding != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d commands (%0d adds, %0d removes) in %0d cycles",
                 adds_sent + removes_sent, adds_sent, removes_sent, cycle_count);
        $display("%0d responses checked, %0d tasks popped, %0d mismatches",
                 responses_checked, tasks_popped, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
